@@ rtl/sha1he_pkg.sv @@
// Shared types, constants and round functions of the SHA-1 hash engine.
package sha1he_pkg;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_EMIT
    } core_state_t;

    typedef struct packed
    {
        logic [7:0] data;
        logic       present;
        logic       last;
    } msg_entry_t;

    typedef struct packed
    {
        logic       valid;
        msg_entry_t entry;
    } queue_head_t;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [5:0] LEN_POS     = 6'd56;
    localparam logic [5:0] BLOCK_LAST  = 6'd63;
    localparam logic [6:0] ROUND_LAST  = 7'd79;
    localparam logic [6:0] STAGE1_FIRST = 7'd20;
    localparam logic [6:0] STAGE2_FIRST = 7'd40;
    localparam logic [6:0] STAGE3_FIRST = 7'd60;
    localparam logic [2:0] WORD_LAST   = 3'd4;
    localparam logic [2:0] LEN_LAST    = 3'd7;

    function automatic logic [31:0] round_k(input logic [6:0] rnd);
        logic [31:0] k;
        if (rnd < STAGE1_FIRST)
        begin
            k = K0;
        end
        else if (rnd < STAGE2_FIRST)
        begin
            k = K1;
        end
        else if (rnd < STAGE3_FIRST)
        begin
            k = K2;
        end
        else
        begin
            k = K3;
        end
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (rnd < STAGE1_FIRST)
        begin
            f = (b & c) | (~b & d);
        end
        else if (rnd >= STAGE2_FIRST && rnd < STAGE3_FIRST)
        begin
            f = (b & c) | (b & d) | (c & d);
        end
        else
        begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

endpackage

@@ rtl/sha1he_front.sv @@
// Input side: accepts words, drops empty ones and queues the rest for the core.
module sha1he_front #(
    parameter int DEPTH = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   msg_valid,
    output logic                   msg_stall,
    input  logic [7:0]             data_byte,
    input  logic                   byte_present,
    input  logic                   end_of_message,
    output sha1he_pkg::queue_head_t head,
    input  logic                   pop
);
    import sha1he_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    msg_entry_t      entries_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   fill_reg;
    logic [CW-1:0]   fill_next;
    logic            push;
    logic            take;

    // A word with neither a byte nor an end mark changes nothing and is dropped here.
    assign msg_stall = (fill_reg == CW'(DEPTH));
    assign push      = msg_valid && !msg_stall && (byte_present || end_of_message);
    assign take      = pop && (fill_reg != '0);

    assign head.valid = (fill_reg != '0);
    assign head.entry = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (take)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !take)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (take && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= '{data: data_byte, present: byte_present,
                                         last: end_of_message};
        end
    end

endmodule

@@ rtl/sha1he_core.sv @@
// Hash core: block packing, 80-round compression, padding and digest output.
module sha1he_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sha1he_pkg::queue_head_t head,
    output logic                    pop,
    output logic                    digest_valid,
    input  logic                    digest_stall,
    output logic [31:0]             digest_word,
    output logic [2:0]              word_index,
    output logic                    last_word
);
    import sha1he_pkg::*;

    core_state_t  state_reg;
    core_state_t  state_next;

    // The block store is a word shift line: bytes shift in at the tail, and
    // during the rounds the schedule shifts in one new word per round.
    logic [31:0]  w_reg [16];
    logic [31:0]  w_next [16];
    logic [31:0]  round_reg [5];
    logic [31:0]  round_next [5];
    logic [31:0]  chain_reg [5];
    logic [31:0]  chain_next [5];
    logic [5:0]   pos_reg;
    logic [5:0]   pos_next;
    logic [60:0]  count_reg;
    logic [60:0]  count_next;
    logic [6:0]   rnd_reg;
    logic [6:0]   rnd_next;
    logic         pad_act_reg;
    logic         pad_act_next;
    logic         sent80_reg;
    logic         sent80_next;
    logic         len_act_reg;
    logic         len_act_next;
    logic [2:0]   len_cnt_reg;
    logic [2:0]   len_cnt_next;
    logic         final_reg;
    logic         final_next;
    logic [2:0]   emit_idx_reg;
    logic [2:0]   emit_idx_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic [31:0]  out_word_reg;
    logic [31:0]  out_word_next;
    logic [2:0]   out_idx_reg;
    logic [2:0]   out_idx_next;
    logic         out_last_reg;
    logic         out_last_next;

    logic         shift_byte;
    logic [7:0]   byte_in;
    logic [63:0]  len_bits;
    logic [7:0]   len_byte;
    logic [31:0]  sched_word;
    logic [31:0]  temp;
    logic         slot_free;

    assign len_bits   = {count_reg, 3'b000};
    assign len_byte   = len_bits[{~len_cnt_reg, 3'b000} +: 8];
    assign sched_word = {w_reg[13][30:0] ^ w_reg[8][30:0] ^ w_reg[2][30:0] ^ w_reg[0][30:0],
                         w_reg[13][31] ^ w_reg[8][31] ^ w_reg[2][31] ^ w_reg[0][31]};
    assign temp       = {round_reg[0][26:0], round_reg[0][31:27]}
                      + round_f(rnd_reg, round_reg[1], round_reg[2], round_reg[3])
                      + round_reg[4] + w_reg[0] + round_k(rnd_reg);
    assign slot_free  = !out_valid_reg || !digest_stall;

    assign digest_valid = out_valid_reg;
    assign digest_word  = out_word_reg;
    assign word_index   = out_idx_reg;
    assign last_word    = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        w_next         = w_reg;
        round_next     = round_reg;
        chain_next     = chain_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        rnd_next       = rnd_reg;
        pad_act_next   = pad_act_reg;
        sent80_next    = sent80_reg;
        len_act_next   = len_act_reg;
        len_cnt_next   = len_cnt_reg;
        final_next     = final_reg;
        emit_idx_next  = emit_idx_reg;
        out_valid_next = out_valid_reg && digest_stall;
        out_word_next  = out_word_reg;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        shift_byte     = 1'b0;
        byte_in        = head.entry.data;

        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (head.entry.present)
                    begin
                        shift_byte = 1'b1;
                        count_next = count_reg + 61'd1;
                        pad_act_next = head.entry.last;
                        if (pos_reg == BLOCK_LAST)
                        begin
                            state_next = ST_ROUND;
                        end
                        else if (head.entry.last)
                        begin
                            state_next = ST_PAD;
                        end
                    end
                    else
                    begin
                        pad_act_next = 1'b1;
                        state_next   = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                shift_byte = 1'b1;
                if (!sent80_reg)
                begin
                    byte_in     = PAD_BYTE;
                    sent80_next = 1'b1;
                end
                else if (!len_act_reg && pos_reg != LEN_POS)
                begin
                    byte_in = 8'h00;
                end
                else
                begin
                    byte_in      = len_byte;
                    len_act_next = 1'b1;
                    len_cnt_next = len_cnt_reg + 3'd1;
                    if (len_cnt_reg == LEN_LAST)
                    begin
                        final_next = 1'b1;
                    end
                end
                if (pos_reg == BLOCK_LAST)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_next[i] = w_reg[i + 1];
                end
                w_next[15]    = sched_word;
                round_next[4] = round_reg[3];
                round_next[3] = round_reg[2];
                round_next[2] = {round_reg[1][1:0], round_reg[1][31:2]};
                round_next[1] = round_reg[0];
                round_next[0] = temp;
                rnd_next      = rnd_reg + 7'd1;
                if (rnd_reg == ROUND_LAST)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                for (int i = 0; i < 5; i++)
                begin
                    chain_next[i] = chain_reg[i] + round_reg[i];
                end
                if (final_reg)
                begin
                    state_next = ST_EMIT;
                end
                else if (pad_act_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = chain_reg[emit_idx_reg];
                    out_idx_next   = emit_idx_reg;
                    out_last_next  = (emit_idx_reg == WORD_LAST);
                    emit_idx_next  = emit_idx_reg + 3'd1;
                    if (emit_idx_reg == WORD_LAST)
                    begin
                        // Digest is out: start over for the next message.
                        chain_next[0] = H0_INIT;
                        chain_next[1] = H1_INIT;
                        chain_next[2] = H2_INIT;
                        chain_next[3] = H3_INIT;
                        chain_next[4] = H4_INIT;
                        pos_next      = '0;
                        count_next    = '0;
                        pad_act_next  = 1'b0;
                        sent80_next   = 1'b0;
                        len_act_next  = 1'b0;
                        len_cnt_next  = '0;
                        final_next    = 1'b0;
                        emit_idx_next = '0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (shift_byte)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_next[i] = {w_reg[i][23:0], w_reg[i + 1][31:24]};
            end
            w_next[15] = {w_reg[15][23:0], byte_in};
            pos_next   = pos_reg + 6'd1;
            if (pos_reg == BLOCK_LAST)
            begin
                // The block is full: load the working variables for round zero.
                round_next = chain_reg;
                rnd_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chain_reg[0]  <= H0_INIT;
            chain_reg[1]  <= H1_INIT;
            chain_reg[2]  <= H2_INIT;
            chain_reg[3]  <= H3_INIT;
            chain_reg[4]  <= H4_INIT;
            pos_reg       <= '0;
            count_reg     <= '0;
            rnd_reg       <= '0;
            pad_act_reg   <= 1'b0;
            sent80_reg    <= 1'b0;
            len_act_reg   <= 1'b0;
            len_cnt_reg   <= '0;
            final_reg     <= 1'b0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chain_reg     <= chain_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            rnd_reg       <= rnd_next;
            pad_act_reg   <= pad_act_next;
            sent80_reg    <= sent80_next;
            len_act_reg   <= len_act_next;
            len_cnt_reg   <= len_cnt_next;
            final_reg     <= final_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg        <= w_next;
        round_reg    <= round_next;
        out_word_reg <= out_word_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
    end

endmodule

@@ rtl/sha1_hash_engine_unit.sv @@
// Streaming SHA-1 hash engine: top level joining the input queue and the hash core.
//
// Input channel (msg_valid / msg_stall): one word per handshake carries at most one
// message byte (data_byte when byte_present is 1); end_of_message closes the message
// after that byte. Words with neither a byte nor an end mark are accepted and ignored.
// Words enter a QUEUE_DEPTH-entry queue, so the sender stalls only when it is full.
// Output channel (digest_valid / digest_stall): five words per message, H0 first,
// word_index 0 to 4, last_word on the fifth. The output register holds a word while
// the receiver stalls; the core then waits, and the queue keeps accepting until full.
// Bytes are packed into the block as they leave the queue; each full 64-byte block is
// then compressed in 80 rounds by the single round unit and a chaining add, and the
// core takes no bytes meanwhile. After the end mark, padding feeds one byte per cycle
// (up to 72 pad bytes, with one or two compressions), then the five digest words
// leave at one per cycle when not stalled.
// Reset clears the queue, loads the SHA-1 initial chaining value and empties the
// block; after each digest the core returns to that state for the next message.
module sha1_hash_engine_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        msg_valid,
    output logic        msg_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        digest_valid,
    input  logic        digest_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import sha1he_pkg::*;

    queue_head_t head;
    logic        pop;

    sha1he_front #(
        .DEPTH(QUEUE_DEPTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .msg_valid      (msg_valid),
        .msg_stall      (msg_stall),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .head           (head),
        .pop            (pop)
    );

    sha1he_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest_word  (digest_word),
        .word_index   (word_index),
        .last_word    (last_word)
    );

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("core took a word from an empty queue");

    a_last_on_fifth: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (last_word == (word_index == WORD_LAST)))
        else $error("last mark does not match the fifth digest word");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (word_index <= WORD_LAST))
        else $error("digest word index out of range");

    a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && !digest_stall && !last_word && $past(rst_n)) ##1 digest_valid
            |-> (word_index == $past(word_index) + 3'd1))
        else $error("digest words out of order");

endmodule
